/* hdl/hcb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcb_pkg
// Shared widths, codes and payload types of the hardware context binder.
// ----------------------------------------------------------------------------
package hcb_pkg;

	localparam int OWNER_W   = 16;
	localparam int MASK_W    = 4;
	localparam int COUNT_W   = 8;
	localparam int OUT_IDX_W = 2;
	localparam int CFG_IDX_W = 2;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

	// request commands
	localparam logic CMD_BIND   = 1'b0;
	localparam logic CMD_UNBIND = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SEQUENCER_MASK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_MASK  = 2'd1;

	typedef enum logic [2:0] {
		ST_BOUND     = 3'd0,
		ST_ALREADY   = 3'd1,
		ST_NONE_FREE = 3'd2,
		ST_RELEASED  = 3'd3,
		ST_HELD      = 3'd4,
		ST_NOT_BOUND = 3'd5
	} status_t;

	typedef struct packed {
		logic               cmd;
		logic [OWNER_W-1:0] owner_id;
		logic               slice_req;
		logic               nr3d_on;
		logic               slow_motion;
		logic               pyramid_on;
	} req_payload_t;

	typedef struct packed {
		status_t              status;
		logic [OUT_IDX_W-1:0] context_index;
		logic [COUNT_W-1:0]   use_count;
	} rsp_payload_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic rsp_full;
	} dp_status_t;

endpackage

/* hdl/hcb_intf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcb_intf
// Request, response and configuration channels of the context binder.
// ----------------------------------------------------------------------------
interface hcb_req_if;
	import hcb_pkg::*;
	logic               valid;
	logic               ready;
	logic               cmd;
	logic [OWNER_W-1:0] owner_id;
	logic               slice_req;
	logic               nr3d_on;
	logic               slow_motion;
	logic               pyramid_on;

	modport source (output valid, cmd, owner_id, slice_req, nr3d_on, slow_motion,
		pyramid_on, input ready);
	modport sink (input valid, cmd, owner_id, slice_req, nr3d_on, slow_motion,
		pyramid_on, output ready);
endinterface

interface hcb_rsp_if;
	import hcb_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [2:0]           status;
	logic [OUT_IDX_W-1:0] context_index;
	logic [COUNT_W-1:0]   use_count;

	modport source (output valid, status, context_index, use_count, input ready);
	modport sink (input valid, status, context_index, use_count, output ready);
endinterface

interface hcb_cfg_if;
	import hcb_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [MASK_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* hdl/hcb_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcb_ctrl
// Request sequencer: take one request, then execute it once the response
// register has room.
// ----------------------------------------------------------------------------
module hcb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  hcb_pkg::dp_status_t dp_status,
	output hcb_pkg::dp_cmd_t    dp_cmd
);
	import hcb_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   ready_q;

	assign req_ready   = ready_q;
	assign dp_cmd.load = req_valid && ready_q;
	assign dp_cmd.exec = (state_q == S_EXEC) && !dp_status.rsp_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ready_q <= 1'b1;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid && ready_q) begin
						state_q <= S_EXEC;
						ready_q <= 1'b0;
					end
				end
				S_EXEC: begin
					// hold until the response register can take the result
					if (!dp_status.rsp_full) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

endmodule

/* hdl/hcb_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcb_datapath
// Context table, owner lookup, free-context search and response register.
// ----------------------------------------------------------------------------
module hcb_datapath #(
	parameter int CONTEXTS = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  hcb_pkg::dp_cmd_t                dp_cmd,
	output hcb_pkg::dp_status_t             dp_status,
	input  hcb_pkg::req_payload_t           req_data,
	input  logic                            cfg_we,
	input  logic [hcb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [hcb_pkg::MASK_W-1:0]      cfg_data,
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output hcb_pkg::rsp_payload_t           rsp_data
);
	import hcb_pkg::*;

	localparam int IDX_W = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;

	// configuration
	logic [MASK_W-1:0] seq_mask_q;
	logic [MASK_W-1:0] res_mask_q;

	// context table
	logic [CONTEXTS-1:0] valid_q;
	logic [OWNER_W-1:0]  tag_q [CONTEXTS];
	logic [COUNT_W-1:0]  cnt_q [CONTEXTS];

	req_payload_t req_q;
	rsp_payload_t rsp_q;
	logic         rsp_valid_q;

	logic [CONTEXTS-1:0] seq_vec;
	logic [CONTEXTS-1:0] res_vec;
	logic [CONTEXTS-1:0] hit_vec;
	logic [CONTEXTS-1:0] free_vec;
	logic [CONTEXTS-1:0] cand0_vec;
	logic [CONTEXTS-1:0] cand1_vec;
	logic [IDX_W-1:0]    hit_idx;
	logic [IDX_W-1:0]    cand0_idx;
	logic [IDX_W-1:0]    cand1_idx;
	logic                must;
	logic                want;
	logic [COUNT_W-1:0]  hit_cnt;
	logic [COUNT_W-1:0]  cnt_inc;
	logic [COUNT_W-1:0]  cnt_dec;

	logic               wr_en;
	logic [IDX_W-1:0]   wr_idx;
	logic               wr_valid;
	logic [OWNER_W-1:0] wr_tag;
	logic [COUNT_W-1:0] wr_cnt;
	status_t            nxt_status;
	logic [IDX_W-1:0]   nxt_idx;
	logic [COUNT_W-1:0] nxt_cnt;
	logic [IDX_W+1:0]   nxt_idx_ext;

	// mask bits exist only for the low contexts
	for (genvar g = 0; g < CONTEXTS; g++) begin : g_mask
		if (g < MASK_W) begin : g_in
			assign seq_vec[g] = seq_mask_q[g];
			assign res_vec[g] = res_mask_q[g];
		end else begin : g_out
			assign seq_vec[g] = 1'b0;
			assign res_vec[g] = 1'b0;
		end
		assign hit_vec[g]  = valid_q[g] && (tag_q[g] == req_q.owner_id);
		assign free_vec[g] = !valid_q[g] && !res_vec[g];
	end

	assign must      = (req_q.slice_req && req_q.nr3d_on) || req_q.slow_motion ||
		req_q.pyramid_on;
	assign want      = req_q.slice_req || must;
	assign cand0_vec = free_vec & ~(seq_vec ^ {CONTEXTS{want}});
	assign cand1_vec = must ? '0 : free_vec;

	// lowest set bit wins
	always_comb begin
		hit_idx   = '0;
		cand0_idx = '0;
		cand1_idx = '0;
		for (int i = CONTEXTS - 1; i >= 0; i--) begin
			if (hit_vec[i])   hit_idx   = IDX_W'(i);
			if (cand0_vec[i]) cand0_idx = IDX_W'(i);
			if (cand1_vec[i]) cand1_idx = IDX_W'(i);
		end
	end

	assign hit_cnt = cnt_q[hit_idx];
	assign cnt_inc = (hit_cnt != COUNT_MAX) ? hit_cnt + 1'b1 : hit_cnt;
	assign cnt_dec = (hit_cnt != '0) ? hit_cnt - 1'b1 : hit_cnt;

	always_comb begin
		wr_en      = 1'b0;
		wr_idx     = hit_idx;
		wr_valid   = 1'b1;
		wr_tag     = req_q.owner_id;
		wr_cnt     = cnt_inc;
		nxt_status = ST_NONE_FREE;
		nxt_idx    = '0;
		nxt_cnt    = '0;
		case (req_q.cmd)
			CMD_BIND: begin
				if (|hit_vec) begin
					wr_en      = 1'b1;
					nxt_status = ST_ALREADY;
					nxt_idx    = hit_idx;
					nxt_cnt    = cnt_inc;
				end else if (|cand0_vec || |cand1_vec) begin
					wr_en      = 1'b1;
					wr_idx     = (|cand0_vec) ? cand0_idx : cand1_idx;
					wr_cnt     = COUNT_W'(1);
					nxt_status = ST_BOUND;
					nxt_idx    = wr_idx;
					nxt_cnt    = COUNT_W'(1);
				end
			end
			CMD_UNBIND: begin
				if (!(|hit_vec)) begin
					nxt_status = ST_NOT_BOUND;
				end else if (cnt_dec == '0) begin
					wr_en      = 1'b1;
					wr_valid   = 1'b0;
					wr_tag     = '0;
					wr_cnt     = '0;
					nxt_status = ST_RELEASED;
					nxt_idx    = hit_idx;
				end else begin
					wr_en      = 1'b1;
					wr_cnt     = cnt_dec;
					nxt_status = ST_HELD;
					nxt_idx    = hit_idx;
					nxt_cnt    = cnt_dec;
				end
			end
			default: begin
				nxt_status = ST_NONE_FREE;
			end
		endcase
	end

	assign nxt_idx_ext = {2'b00, nxt_idx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_mask_q <= '0;
			res_mask_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SEQUENCER_MASK: seq_mask_q <= cfg_data;
				CFG_RESERVED_MASK:  res_mask_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.load) begin
			req_q <= req_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (dp_cmd.exec && wr_en) begin
			for (int i = 0; i < CONTEXTS; i++) begin
				if (wr_idx == IDX_W'(i)) valid_q[i] <= wr_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.exec && wr_en) begin
			for (int i = 0; i < CONTEXTS; i++) begin
				if (wr_idx == IDX_W'(i)) begin
					tag_q[i] <= wr_tag;
					cnt_q[i] <= wr_cnt;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (dp_cmd.exec) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.exec) begin
			rsp_q.status        <= nxt_status;
			rsp_q.context_index <= nxt_idx_ext[OUT_IDX_W-1:0];
			rsp_q.use_count     <= nxt_cnt;
		end
	end

	assign dp_status.rsp_full = rsp_valid_q && !rsp_ready;
	assign rsp_valid          = rsp_valid_q;
	assign rsp_data           = rsp_q;

endmodule

/* hdl/hw_context_binder_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hw_context_binder_unit
// Reference-counted binder of software owners to a small pool of contexts.
// Requests are captured, then executed once the response register has room.
// The two-state sequencer (capture, then lookup, search and table update in
// the execute state) takes no new request until the last one has executed.
// Reset: all contexts unbound, both masks zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
module hw_context_binder_unit #(
	parameter int CONTEXTS = 4
) (
	input logic       clk,
	input logic       arst_n,
	hcb_req_if.sink   req,
	hcb_rsp_if.source rsp,
	hcb_cfg_if.sink   cfg
);
	import hcb_pkg::*;

	dp_cmd_t      dp_cmd;
	dp_status_t   dp_status;
	req_payload_t req_data;
	rsp_payload_t rsp_data;
	logic         rsp_valid;

	// pack the request fields for the capture register
	assign req_data.cmd         = req.cmd;
	assign req_data.owner_id    = req.owner_id;
	assign req_data.slice_req   = req.slice_req;
	assign req_data.nr3d_on     = req.nr3d_on;
	assign req_data.slow_motion = req.slow_motion;
	assign req_data.pyramid_on  = req.pyramid_on;

	// masks only steer the search, so a write is always taken at once
	assign cfg.ready = 1'b1;

	hcb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.dp_status (dp_status),
		.dp_cmd    (dp_cmd)
	);

	hcb_datapath #(
		.CONTEXTS (CONTEXTS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.dp_cmd    (dp_cmd),
		.dp_status (dp_status),
		.req_data  (req_data),
		.cfg_we    (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp.ready),
		.rsp_data  (rsp_data)
	);

	// drive the response channel from the output register
	assign rsp.valid         = rsp_valid;
	assign rsp.status        = rsp_data.status;
	assign rsp.context_index = rsp_data.context_index;
	assign rsp.use_count     = rsp_data.use_count;

	// a request transfer closes the request side until it has executed
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request taken while another is in execution");

	// a new result only appears from an execute cycle
	a_result_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(!req.ready))
		else $error("result appeared without an executing request");

	// a fresh binding, a release and a miss report fixed counts
	a_bound_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == ST_BOUND) |-> (rsp.use_count == COUNT_W'(1)))
		else $error("new binding with count other than one");

	a_released_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.status == ST_RELEASED || rsp.status == ST_NOT_BOUND))
		|-> (rsp.use_count == '0))
		else $error("release or miss with nonzero count");

endmodule

/* sim/hcb_binder_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcb_binder_checker
// Tracks the context table from observed request and register transfers,
// predicts each response and compares response transfers in order.
// ----------------------------------------------------------------------------
module hcb_binder_checker #(
	parameter int CONTEXTS = 4
) (
	input  logic clk,
	input  logic arst_n,
	hcb_req_if   req,
	hcb_rsp_if   rsp,
	hcb_cfg_if   cfg,
	input  logic drain_done,
	output int   answers_due,
	output int   fails
);
	import hcb_pkg::*;

	logic [CONTEXTS-1:0] held;
	logic [OWNER_W-1:0]  holder [CONTEXTS];
	logic [COUNT_W-1:0]  refs [CONTEXTS];
	logic [MASK_W-1:0]   seq_mask;
	logic [MASK_W-1:0]   rsv_mask;
	rsp_payload_t        answer_q[$];
	rsp_payload_t        head;
	req_payload_t        seen;
	bit                  drain_seen;

	task automatic flag_mismatch(input string what);
		fails++;
		$display("[%0t] MISMATCH %s", $time, what);
	endtask

	function automatic logic mask_bit(input logic [MASK_W-1:0] mask, input int i);
		return (i < MASK_W) ? mask[i] : 1'b0;
	endfunction

	// Work out one response and update the table the way the block must.
	function automatic rsp_payload_t resolve_request(input req_payload_t r);
		rsp_payload_t a;
		int           hit;
		logic         must;
		logic         want;
		bit           found;
		hit             = -1;
		found           = 1'b0;
		a.status        = ST_NONE_FREE;
		a.context_index = '0;
		a.use_count     = '0;
		for (int i = 0; i < CONTEXTS; i++)
			if (hit < 0 && held[i] && holder[i] == r.owner_id)
				hit = i;
		if (r.cmd == CMD_BIND) begin
			if (hit >= 0) begin
				if (refs[hit] != COUNT_MAX)
					refs[hit]++;
				a.status        = ST_ALREADY;
				a.context_index = hit[OUT_IDX_W-1:0];
				a.use_count     = refs[hit];
			end else begin
				must = (r.slice_req && r.nr3d_on) || r.slow_motion || r.pyramid_on;
				want = r.slice_req || must;
				// first pass matches the sequencer wish, second takes anything free but is skipped for a must
				for (int pass = 0; pass < 2; pass++)
					for (int i = 0; i < CONTEXTS; i++)
						if (!found && !(must && pass == 1) && !held[i]
								&& !mask_bit(rsv_mask, i)
								&& (pass == 1 || mask_bit(seq_mask, i) == want)) begin
							found           = 1'b1;
							held[i]         = 1'b1;
							holder[i]       = r.owner_id;
							refs[i]         = COUNT_W'(1);
							a.status        = ST_BOUND;
							a.context_index = i[OUT_IDX_W-1:0];
							a.use_count     = COUNT_W'(1);
						end
			end
		end else if (hit < 0) begin
			a.status = ST_NOT_BOUND;
		end else begin
			if (refs[hit] != 0)
				refs[hit]--;
			a.context_index = hit[OUT_IDX_W-1:0];
			if (refs[hit] == 0) begin
				held[hit]   = 1'b0;
				holder[hit] = '0;
				a.status    = ST_RELEASED;
			end else begin
				a.status    = ST_HELD;
				a.use_count = refs[hit];
			end
		end
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held       = '0;
			seq_mask   = '0;
			rsv_mask   = '0;
			drain_seen = 1'b0;
			fails      = 0;
			for (int i = 0; i < CONTEXTS; i++) begin
				holder[i] = '0;
				refs[i]   = '0;
			end
			answer_q.delete();
			answers_due <= 0;
		end else begin
			// a response never answers a request of the same edge: pop first
			if (rsp.valid && rsp.ready) begin
				if (answer_q.size() == 0) begin
					flag_mismatch($sformatf(
						"response with nothing outstanding: status %0d idx %0d count %0d",
						rsp.status, rsp.context_index, rsp.use_count));
				end else begin
					head = answer_q.pop_front();
					if (rsp.status !== head.status)
						flag_mismatch($sformatf("status got %0d want %0d", rsp.status, head.status));
					if (rsp.context_index !== head.context_index)
						flag_mismatch($sformatf("context_index got %0d want %0d",
							rsp.context_index, head.context_index));
					if (rsp.use_count !== head.use_count)
						flag_mismatch($sformatf("use_count got %0d want %0d",
							rsp.use_count, head.use_count));
				end
			end
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == CFG_SEQUENCER_MASK)
					seq_mask = cfg.data;
				else if (cfg.index == CFG_RESERVED_MASK)
					rsv_mask = cfg.data;
			end
			if (req.valid && req.ready) begin
				seen.cmd         = req.cmd;
				seen.owner_id    = req.owner_id;
				seen.slice_req   = req.slice_req;
				seen.nr3d_on     = req.nr3d_on;
				seen.slow_motion = req.slow_motion;
				seen.pyramid_on  = req.pyramid_on;
				answer_q.push_back(resolve_request(seen));
			end
			if (drain_done && !drain_seen) begin
				drain_seen = 1'b1;
				foreach (answer_q[k])
					flag_mismatch($sformatf("response never arrived: status %0d idx %0d",
						answer_q[k].status, answer_q[k].context_index));
				answer_q.delete();
			end
			answers_due <= answer_q.size();
		end
	end

endmodule

/* sim/hw_context_binder_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hw_context_binder_unit_tb
// Drives bind and unbind requests and mask writes into the context binder
// with random idle bursts on both sides; a checker beside the block predicts
// and compares every response.
// ----------------------------------------------------------------------------
module hw_context_binder_unit_tb;
	import hcb_pkg::*;

	localparam int CONTEXTS    = 4;
	localparam int STALL_LIMIT = 5000;
	localparam int POOL        = 6;

	// register slots the block does not decode
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

	// request flags packed as {slice_req, nr3d_on, slow_motion, pyramid_on}
	localparam logic [3:0] F_NONE   = 4'b0000;
	localparam logic [3:0] F_SLICE  = 4'b1000;
	localparam logic [3:0] F_SLC3D  = 4'b1100;
	localparam logic [3:0] F_SLOW   = 4'b0010;
	localparam logic [3:0] F_PYR    = 4'b0001;
	localparam logic [3:0] F_ALL    = 4'b1111;

	logic clk = 1'b0;
	logic arst_n;
	logic drain_done;
	int   answers_due;
	int   fails;
	bit   noisy;
	int   stall_left   = 0;
	int   quiet_cycles = 0;

	logic [OWNER_W-1:0] owner_pool [POOL];

	hcb_req_if req ();
	hcb_rsp_if rsp ();
	hcb_cfg_if cfg ();

	hw_context_binder_unit #(.CONTEXTS(CONTEXTS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	hcb_binder_checker #(.CONTEXTS(CONTEXTS)) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.cfg         (cfg),
		.drain_done  (drain_done),
		.answers_due (answers_due),
		.fails       (fails)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Response side: while noisy, drop ready now and then and keep it low while a random stall count runs down.
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			rsp.ready  <= 1'b0;
		end else if (noisy && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 8);
			rsp.ready  <= 1'b0;
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	// Watchdog: end the run when no channel moves a transfer for too long.
	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready)
				|| (cfg.valid && cfg.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Present one request and hold it until the transfer happens.
	task automatic send_request(input logic c, input logic [OWNER_W-1:0] who,
			input logic [3:0] flags);
		req.valid    <= 1'b1;
		req.cmd      <= c;
		req.owner_id <= who;
		{req.slice_req, req.nr3d_on, req.slow_motion, req.pyramid_on} <= flags;
		do @(posedge clk); while (!req.ready);
	endtask

	// Drop valid and wait until every outstanding response has been taken.
	task automatic settle();
		req.valid <= 1'b0;
		do @(posedge clk); while (answers_due != 0);
	endtask

	// Leave cfg.valid high so back-to-back writes never lower and raise it
	// in the same step; the caller drops it after the last write.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [MASK_W-1:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		do @(posedge clk); while (!cfg.ready);
	endtask

	task automatic set_masks(input logic [MASK_W-1:0] seq, input logic [MASK_W-1:0] rsv);
		settle();
		write_reg(CFG_SEQUENCER_MASK, seq);
		write_reg(CFG_RESERVED_MASK, rsv);
		cfg.valid <= 1'b0;
	endtask

	// Now and then drop valid and idle the request side; the length is drawn at random.
	task automatic maybe_pause();
		if (noisy && $urandom_range(0, 3) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	// Mostly pool owners so binds stack up and unbinds find holders; the
	// rest are strangers that exercise the not-bound path.
	task automatic random_traffic(input int count);
		logic               c;
		logic [OWNER_W-1:0] who;
		logic [3:0]         flags;
		repeat (count) begin
			c     = ($urandom_range(0, 99) < 55) ? CMD_BIND : CMD_UNBIND;
			who   = ($urandom_range(0, 9) == 0) ? OWNER_W'($urandom_range(0, 65535))
				: owner_pool[$urandom_range(0, POOL-1)];
			flags = 4'($urandom_range(0, 15));
			maybe_pause();
			// now and then let everything drain before the next request
			if ($urandom_range(0, 39) == 0)
				settle();
			send_request(c, who, flags);
		end
	endtask

	// Sequencer on contexts 0 and 2, context 3 reserved.
	task automatic directed_requests();
		send_request(CMD_UNBIND, 16'h0000, F_NONE);  // nobody holds anything
		send_request(CMD_BIND,   16'h0000, F_NONE);  // plain wish: context 1
		send_request(CMD_BIND,   16'hFFFF, F_SLICE); // wants sequencer: context 0
		send_request(CMD_BIND,   16'h5A5A, F_SLC3D); // slicing with 3DNR is a must
		send_request(CMD_BIND,   16'hA5A5, F_SLOW);  // must, no sequencer left
		send_request(CMD_BIND,   16'hA5A5, F_PYR);
		send_request(CMD_BIND,   16'hA5A5, F_NONE);  // only the reserved one is left
		send_request(CMD_BIND,   16'h0000, F_ALL);   // already bound, count 2
		send_request(CMD_UNBIND, 16'h0000, F_NONE);  // still held
		send_request(CMD_UNBIND, 16'h0000, F_NONE);  // released
		send_request(CMD_UNBIND, 16'h0000, F_NONE);  // gone
		send_request(CMD_BIND,   16'h0001, F_SLICE); // wish unmet, fall back
		send_request(CMD_BIND,   16'hA5A5, F_SLOW);
		send_request(CMD_UNBIND, 16'hFFFF, F_SLICE);
		send_request(CMD_UNBIND, 16'h5A5A, F_NONE);
		send_request(CMD_UNBIND, 16'h0001, F_ALL);
		send_request(CMD_BIND,   16'h8000, F_PYR);
		send_request(CMD_BIND,   16'h7FFE, F_ALL);
		send_request(CMD_BIND,   16'hA5A5, F_NONE);
		send_request(CMD_BIND,   16'h0001, F_SLICE); // no fallback left
		send_request(CMD_UNBIND, 16'h8000, F_NONE);
		send_request(CMD_UNBIND, 16'h7FFE, F_NONE);
		send_request(CMD_UNBIND, 16'hA5A5, F_NONE);
	endtask

	initial begin
		logic [OWNER_W-1:0] heavy;
		logic [MASK_W-1:0]  seq;
		logic [MASK_W-1:0]  rsv;

		// drive every input to a known value from the first instant
		arst_n          = 1'b0;
		drain_done      = 1'b0;
		noisy           = 1'b1;
		req.valid       = 1'b0;
		req.cmd         = CMD_BIND;
		req.owner_id    = '0;
		req.slice_req   = 1'b0;
		req.nr3d_on     = 1'b0;
		req.slow_motion = 1'b0;
		req.pyramid_on  = 1'b0;
		rsp.ready       = 1'b0;
		cfg.valid       = 1'b0;
		cfg.index       = CFG_SEQUENCER_MASK;
		cfg.data        = '0;
		foreach (owner_pool[k])
			owner_pool[k] = OWNER_W'($urandom_range(0, 65535));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_masks(4'b0101, 4'b1000);
		directed_requests();

		// undecoded slots must leave both masks alone
		settle();
		write_reg(CFG_SPARE_A, MASK_W'($urandom_range(0, 15)));
		write_reg(CFG_SPARE_B, MASK_W'($urandom_range(0, 15)));
		cfg.valid <= 1'b0;

		// Drive one owner past count saturation, then unbind it all the way
		// down to release and once more after that.
		set_masks(4'hF, 4'h0);
		heavy = OWNER_W'($urandom_range(0, 65535));
		repeat ($urandom_range(256, 262)) begin
			maybe_pause();
			send_request(CMD_BIND, heavy, 4'($urandom_range(0, 15)));
		end
		repeat (int'(COUNT_MAX) + 1) begin
			maybe_pause();
			send_request(CMD_UNBIND, heavy, 4'($urandom_range(0, 15)));
		end

		// Random phases across mask settings; owners keep their contexts
		// through the mask changes. Phase 3 and the last phase run clean.
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: begin seq = 4'h0; rsv = 4'h0; end
				1: begin seq = 4'hF; rsv = 4'h0; end
				2: begin seq = 4'h0; rsv = 4'hF; end
				3: begin seq = 4'hF; rsv = 4'hF; end
				4: begin seq = 4'hA; rsv = 4'h5; end
				5: begin seq = 4'h5; rsv = 4'h2; end
				default: begin
					seq = MASK_W'($urandom_range(0, 15));
					rsv = MASK_W'($urandom_range(0, 15));
				end
			endcase
			set_masks(seq, rsv);
			noisy = (phase != 3 && phase != 7);
			owner_pool[$urandom_range(0, POOL-1)] = OWNER_W'($urandom_range(0, 65535));
			owner_pool[$urandom_range(0, POOL-1)] = OWNER_W'($urandom_range(0, 65535));
			random_traffic(100);
		end

		// drain, wait for stray responses, then judge
		settle();
		repeat (4) @(posedge clk);
		drain_done <= 1'b1;
		repeat (2) @(posedge clk);
		if (fails == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
